/* rtl/kdlp_pkg.sv */
`timescale 1ns / 1ps

package kdlp_pkg;

  localparam int KEY_W      = 8;
  localparam int DEB_W      = 8;
  localparam int REPEAT_W   = 16;
  localparam int START_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_MASK = 3'd4;

  localparam logic [DEB_W-1:0]    DEBOUNCE_RST   = 8'd3;
  localparam logic [START_W-1:0]  LONG_START_RST = 16'd100;
  localparam logic [REPEAT_W-1:0] REPEAT_RST     = 16'd20;
  localparam logic [KEY_W-1:0]    LONG_MASK_RST  = 8'hFF;
  localparam logic [KEY_W-1:0]    SHORT_MASK_RST = 8'hFF;

  localparam logic [REPEAT_W-1:0] REPEAT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [DEB_W-1:0]    debounce_ticks;
    logic [START_W-1:0]  long_start_ticks;
    logic [REPEAT_W-1:0] repeat_ticks;
  } timing_cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
    logic held;
  } lane_res_t;

endpackage

/* rtl/kdlp_lane.sv */
`timescale 1ns / 1ps

module kdlp_lane
  import kdlp_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        advance,
  input  logic        pressed,
  input  logic        long_en,
  input  logic        short_en,
  input  timing_cfg_t cfg,
  output lane_res_t   res
);

  localparam int CMP_W = (TIMER_BITS > START_W) ? TIMER_BITS : START_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [DEB_W-1:0]      dcnt_r, dcnt_nxt;
  logic [TIMER_BITS-1:0] ptimer_r, ptimer_nxt;
  logic [REPEAT_W-1:0]   rtimer_r, rtimer_nxt;
  logic                  held_r, held_nxt;
  logic                  fired_r, fired_nxt;
  logic [TIMER_BITS-1:0] pt_base, pt_inc;
  logic [REPEAT_W-1:0]   rt_inc;
  logic                  start;

  always_comb begin
    dcnt_nxt   = dcnt_r;
    ptimer_nxt = ptimer_r;
    rtimer_nxt = rtimer_r;
    held_nxt   = held_r;
    fired_nxt  = fired_r;
    pt_base    = '0;
    pt_inc     = '0;
    rt_inc     = '0;
    start      = 1'b0;
    res        = '0;
    if (pressed) begin
      if (dcnt_r < cfg.debounce_ticks) begin
        dcnt_nxt = dcnt_r + 8'd1;
      end else begin
        held_nxt   = 1'b1;
        pt_base    = held_r ? ptimer_r : '0;
        ptimer_nxt = pt_base;
        if (pt_base != TIMER_MAX) begin
          pt_inc     = pt_base + 1'b1;
          ptimer_nxt = pt_inc;
          if ((CMP_W'(pt_inc) == CMP_W'(cfg.long_start_ticks)) && long_en) begin
            start       = 1'b1;
            fired_nxt   = 1'b1;
            rtimer_nxt  = '0;
            res.long_ev = 1'b1;
          end
        end
        if (!start && fired_r && (rtimer_r != REPEAT_MAX)) begin
          rt_inc = rtimer_r + 16'd1;
          if (rt_inc == cfg.repeat_ticks) begin
            res.long_ev = 1'b1;
            rtimer_nxt  = '0;
          end else begin
            rtimer_nxt = rt_inc;
          end
        end
      end
    end else begin
      res.short_ev = held_r && !fired_r && short_en;
      dcnt_nxt     = '0;
      ptimer_nxt   = '0;
      rtimer_nxt   = '0;
      held_nxt     = 1'b0;
      fired_nxt    = 1'b0;
    end
    res.held = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r   <= '0;
      ptimer_r <= '0;
      rtimer_r <= '0;
      held_r   <= 1'b0;
      fired_r  <= 1'b0;
    end else if (advance) begin
      dcnt_r   <= dcnt_nxt;
      ptimer_r <= ptimer_nxt;
      rtimer_r <= rtimer_nxt;
      held_r   <= held_nxt;
      fired_r  <= fired_nxt;
    end
  end

endmodule

/* rtl/kdlp_merge.sv */
`timescale 1ns / 1ps

module kdlp_merge
  import kdlp_pkg::*;
#(
  parameter int LANES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lane_res_t [LANES-1:0] res,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_W-1:0]      out_short_events,
  output logic [KEY_W-1:0]      out_long_events,
  output logic [KEY_W-1:0]      out_held_keys
);

  logic [KEY_W-1:0] short_w, long_w, held_w;
  logic [KEY_W-1:0] out_short_r, out_long_r, out_held_r;
  logic [KEY_W-1:0] skid_short_r, skid_long_r, skid_held_r;
  logic             out_valid_r, skid_valid_r;
  logic             in_acc, out_free;

  always_comb begin
    short_w = '0;
    long_w  = '0;
    held_w  = '0;
    for (int i = 0; i < LANES; i++) begin
      short_w[i] = res[i].short_ev;
      long_w[i]  = res[i].long_ev;
      held_w[i]  = res[i].held;
    end
  end

  assign in_ready = !skid_valid_r;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_acc;
      end
    end else if (in_acc) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_short_r <= skid_short_r;
        out_long_r  <= skid_long_r;
        out_held_r  <= skid_held_r;
      end else if (in_acc) begin
        out_short_r <= short_w;
        out_long_r  <= long_w;
        out_held_r  <= held_w;
      end
    end else if (in_acc) begin
      skid_short_r <= short_w;
      skid_long_r  <= long_w;
      skid_held_r  <= held_w;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_short_events = out_short_r;
  assign out_long_events  = out_long_r;
  assign out_held_keys    = out_held_r;

endmodule

/* rtl/key_debounce_long_press.sv */
`timescale 1ns / 1ps
// Debounced key scanner with short, long and repeat press events.
// Input channel (in_valid/in_ready/in_pin_levels): one request per scan tick,
// carrying the raw pin level of every key, low meaning pressed.
// Result channel (out_valid/out_ready/out_*): exactly one request per tick with
// short events, long/repeat events and the debounced held state after that tick.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is always
// high; index 0 debounce, 1 long start, 2 repeat interval, 3 long enable mask,
// 4 short enable mask; other indexes are dropped. Write only while idle.
// Each key has its own lane of counters; all lanes advance in the cycle a tick
// is accepted and the merge stage registers their bits as one result.
// Results are registered in the merge stage output register, or in its skid entry.
// Throughput: one tick per cycle while in_ready is high, set by the lane update.
// Receiver stall: an output register plus one skid entry hold results; in_ready
// drops only once both are full and rises in the cycle after the receiver takes one.
// Reset (rst_n low, synchronous): all key state cleared, registers return to
// 3, 100, 20, 0xFF, 0xFF, no result pending.
module key_debounce_long_press
  import kdlp_pkg::*;
#(
  parameter int NUM_KEYS   = 8,
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KEY_W-1:0]      in_pin_levels,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KEY_W-1:0]      out_short_events,
  output logic [KEY_W-1:0]      out_long_events,
  output logic [KEY_W-1:0]      out_held_keys,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LANES = (NUM_KEYS < KEY_W) ? NUM_KEYS : KEY_W;

  timing_cfg_t          timing_r;
  logic [KEY_W-1:0]     long_mask_r, short_mask_r;
  lane_res_t [LANES-1:0] lane_res;
  logic                 advance;

  assign cfg_ready = 1'b1;
  assign advance   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.debounce_ticks   <= DEBOUNCE_RST;
      timing_r.long_start_ticks <= LONG_START_RST;
      timing_r.repeat_ticks     <= REPEAT_RST;
      long_mask_r               <= LONG_MASK_RST;
      short_mask_r              <= SHORT_MASK_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEBOUNCE:   timing_r.debounce_ticks   <= cfg_data[DEB_W-1:0];
        REG_LONG_START: timing_r.long_start_ticks <= cfg_data[START_W-1:0];
        REG_REPEAT:     timing_r.repeat_ticks     <= cfg_data[REPEAT_W-1:0];
        REG_LONG_MASK:  long_mask_r               <= cfg_data[KEY_W-1:0];
        REG_SHORT_MASK: short_mask_r              <= cfg_data[KEY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    kdlp_lane #(
      .TIMER_BITS(TIMER_BITS)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .advance  (advance),
      .pressed  (!in_pin_levels[g]),
      .long_en  (long_mask_r[g]),
      .short_en (short_mask_r[g]),
      .cfg      (timing_r),
      .res      (lane_res[g])
    );
  end

  kdlp_merge #(
    .LANES(LANES)
  ) u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .res              (lane_res),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_short_events (out_short_events),
    .out_long_events  (out_long_events),
    .out_held_keys    (out_held_keys)
  );

endmodule

/* rtl/kdlp_checker.sv */
`timescale 1ns / 1ps

module kdlp_checker
  import kdlp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [KEY_W-1:0] out_short_events,
  input logic [KEY_W-1:0] out_long_events,
  input logic [KEY_W-1:0] out_held_keys
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_short_long_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_short_events & out_long_events) == '0))
    else $error("short and long event on the same key");

  a_short_released: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_short_events & out_held_keys) == '0))
    else $error("short event on a held key");

  a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_long_events & ~out_held_keys) == '0))
    else $error("long event on a key not held");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind key_debounce_long_press kdlp_checker u_kdlp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_short_events (out_short_events),
  .out_long_events  (out_long_events),
  .out_held_keys    (out_held_keys)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import kdlp_pkg::*;

  localparam int NKEYS = 8;
  localparam logic [15:0] PRESS_MAX = 16'hFFFF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_SHORT_MASK + 1'b1;
  localparam logic [KEY_W-1:0] DIRECTED [20] = '{
    8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF,
    8'h55, 8'h55, 8'h55, 8'h55, 8'h55, 8'hAA,
    8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'h0F, 8'hF0, 8'hFF
  };

  typedef struct packed {
    logic [KEY_W-1:0] shorts;
    logic [KEY_W-1:0] longs;
    logic [KEY_W-1:0] held;
  } scan_res_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic [KEY_W-1:0]      in_pin_levels = '1;
  logic                  out_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_ready;
  logic                  out_valid;
  logic [KEY_W-1:0]      out_short_events;
  logic [KEY_W-1:0]      out_long_events;
  logic [KEY_W-1:0]      out_held_keys;
  logic                  cfg_ready;

  key_debounce_long_press dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pin_levels    (in_pin_levels),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_short_events (out_short_events),
    .out_long_events  (out_long_events),
    .out_held_keys    (out_held_keys),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  logic [DEB_W-1:0]    debounce_lim;
  logic [START_W-1:0]  long_start;
  logic [REPEAT_W-1:0] repeat_gap;
  logic [KEY_W-1:0]    long_en_mask;
  logic [KEY_W-1:0]    short_en_mask;

  logic [DEB_W-1:0]    low_count [NKEYS];
  logic [15:0]         press_count [NKEYS];
  logic [REPEAT_W-1:0] repeat_count [NKEYS];
  logic                is_held [NKEYS];
  logic                long_done [NKEYS];

  scan_res_t        expected_scans [$];
  logic [KEY_W-1:0] pending_ticks [$];
  int ticks_queued = 0;
  int scans_checked = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int in_idle_pct = 0;
  int out_stall_pct = 0;
  bit in_taken = 1'b0;
  bit key_level [NKEYS] = '{default: 1'b1};
  int key_left [NKEYS] = '{default: 0};

  task automatic scan_tick(input logic [KEY_W-1:0] pins, output scan_res_t res);
    logic start_hit;
    res = '0;
    for (int k = 0; k < NKEYS; k++) begin
      if (!pins[k]) begin
        if (low_count[k] < debounce_lim) begin
          low_count[k] = low_count[k] + 1'b1;
        end else begin
          start_hit = 1'b0;
          if (!is_held[k]) begin
            is_held[k] = 1'b1;
            press_count[k] = '0;
          end
          if (press_count[k] != PRESS_MAX) begin
            press_count[k] = press_count[k] + 1'b1;
            if (press_count[k] == long_start && long_en_mask[k]) begin
              res.longs[k] = 1'b1;
              long_done[k] = 1'b1;
              repeat_count[k] = '0;
              start_hit = 1'b1;
            end
          end
          if (!start_hit && long_done[k] && repeat_count[k] != REPEAT_MAX) begin
            repeat_count[k] = repeat_count[k] + 1'b1;
            if (repeat_count[k] == repeat_gap) begin
              res.longs[k] = 1'b1;
              repeat_count[k] = '0;
            end
          end
        end
      end else begin
        if (is_held[k] && !long_done[k] && short_en_mask[k]) res.shorts[k] = 1'b1;
        low_count[k] = '0;
        press_count[k] = '0;
        repeat_count[k] = '0;
        is_held[k] = 1'b0;
        long_done[k] = 1'b0;
      end
      res.held[k] = is_held[k];
    end
  endtask

  always @(posedge clk) begin
    scan_res_t want;
    scan_res_t got;
    if (!rst_n) begin
      debounce_lim = DEBOUNCE_RST;
      long_start = LONG_START_RST;
      repeat_gap = REPEAT_RST;
      long_en_mask = LONG_MASK_RST;
      short_en_mask = SHORT_MASK_RST;
      for (int k = 0; k < NKEYS; k++) begin
        low_count[k] = '0;
        press_count[k] = '0;
        repeat_count[k] = '0;
        is_held[k] = 1'b0;
        long_done[k] = 1'b0;
      end
      expected_scans.delete();
      quiet_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_short_events, out_long_events, out_held_keys};
        if (expected_scans.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: short %h long %h held %h",
                     got.shorts, got.longs, got.held);
        end else begin
          want = expected_scans.pop_front();
          scans_checked++;
          if (got.shorts !== want.shorts || got.longs !== want.longs ||
              got.held !== want.held) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch: short %h/%h long %h/%h held %h/%h (exp/act)",
                       scans_checked, want.shorts, got.shorts, want.longs, got.longs,
                       want.held, got.held);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEBOUNCE:   debounce_lim = cfg_data[DEB_W-1:0];
          REG_LONG_START: long_start = cfg_data[START_W-1:0];
          REG_REPEAT:     repeat_gap = cfg_data[REPEAT_W-1:0];
          REG_LONG_MASK:  long_en_mask = cfg_data[KEY_W-1:0];
          REG_SHORT_MASK: short_en_mask = cfg_data[KEY_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        scan_tick(in_pin_levels, want);
        expected_scans.push_back(want);
        in_taken = 1'b1;
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
      if (!in_valid || in_taken) begin
        in_taken = 1'b0;
        if (pending_ticks.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
          in_valid <= 1'b1;
          in_pin_levels <= pending_ticks.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_tick(input logic [KEY_W-1:0] pins);
    pending_ticks.push_back(pins);
    ticks_queued++;
  endtask

  task automatic queue_random(input int n, input int span, input int noise_pct);
    logic [KEY_W-1:0] pins;
    repeat (n) begin
      for (int k = 0; k < NKEYS; k++) begin
        if (key_left[k] == 0) begin
          key_level[k] = ~key_level[k];
          if (key_level[k]) key_left[k] = $urandom_range(6, 1);
          else if ($urandom_range(1)) key_left[k] = $urandom_range(span / 4 + 1, 1);
          else key_left[k] = $urandom_range(span, span / 2);
        end
        key_left[k]--;
        pins[k] = key_level[k] ^ ($urandom_range(99) < noise_pct);
      end
      if ($urandom_range(99) < noise_pct) pins = KEY_W'($urandom);
      push_tick(pins);
    end
  endtask

  task automatic wait_idle();
    while (scans_checked != ticks_queued) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic write_regs(input logic [DEB_W-1:0] deb, input logic [START_W-1:0] start,
                            input logic [REPEAT_W-1:0] gap, input logic [KEY_W-1:0] lmask,
                            input logic [KEY_W-1:0] smask);
    cfg_write(REG_DEBOUNCE, {8'($urandom), deb});
    cfg_write(REG_LONG_START, start);
    cfg_write(REG_REPEAT, gap);
    cfg_write(REG_LONG_MASK, {8'($urandom), lmask});
    cfg_write(REG_SHORT_MASK, {8'($urandom), smask});
    cfg_write(CFG_IDX_W'($urandom_range((1 << CFG_IDX_W) - 1, REG_FIRST_UNUSED)),
              CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    @(posedge rst_n);
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int d;
    int ls;
    int rp;
    int lm;
    int sm;
    int n;
    int span;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) push_tick(DIRECTED[i]);
    queue_random(80, 200, 3);

    for (int p = 1; p < 8; p++) begin
      n = 40;
      case (p)
        1: begin d = 0; ls = 1; rp = 1; lm = 8'hFF; sm = 8'hFF; end
        2: begin d = 2; ls = 5; rp = 3; lm = $urandom_range(255); sm = $urandom_range(255); end
        3: begin d = 1; ls = 0; rp = 0; lm = 8'hFF; sm = 8'h00; end
        4: begin d = 255; ls = 3; rp = 2; lm = 8'h00; sm = 8'hFF; n = 300; end
        5: begin d = 4; ls = 65535; rp = 65535; lm = 8'hFF; sm = 8'hFF; end
        default: begin
          d = $urandom_range(6);
          ls = $urandom_range(20, 1);
          rp = $urandom_range(8, 1);
          lm = $urandom_range(255);
          sm = $urandom_range(255);
        end
      endcase
      wait_idle();
      write_regs(DEB_W'(d), START_W'(ls), REPEAT_W'(rp), KEY_W'(lm), KEY_W'(sm));
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 53; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 53; end
        default: begin in_idle_pct = 28; out_stall_pct = 28; end
      endcase
      span = d + ls + 3 * rp;
      if (span > 300) span = 300;
      if (span < 8) span = 8;
      queue_random(n, span, (p == 4) ? 0 : 3);
    end

    wait_idle();
    if (errors == 0 && expected_scans.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
